@@ design/pit4ch_pkg.sv @@
package pit4ch_pkg;

   localparam int NUM_CHANNELS_DEF = 4;
   localparam int COUNT_WIDTH_DEF  = 32;

   localparam int FUNC_W = 2;
   localparam int ADDR_W = 9;
   localparam int DATA_W = 32;
   localparam int CTRL_W = 3;
   localparam int CHNUM_W = 4;

   localparam int MOD_CTRL_ADDR = 'h000;
   localparam int CH_BASE       = 'h100;
   localparam int CH_STRIDE     = 'h010;

   // bit positions in the control words
   localparam int MOD_DISABLE_BIT = 1;
   localparam int CTL_EN_BIT      = 0;
   localparam int CTL_IE_BIT      = 1;
   localparam int FLAG_CLR_BIT    = 0;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_WRITE = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      REG_LOAD = 2'd0,
      REG_CVAL = 2'd1,
      REG_CTRL = 2'd2,
      REG_FLAG = 2'd3
   } reg_sel_type;

   typedef struct packed {
      logic               tick;
      logic               read;
      logic               write;
      logic               mod_hit;
      logic               ch_hit;
      logic [CHNUM_W-1:0] ch_num;
      reg_sel_type        reg_sel;
      logic               err;
   } access_type;

endpackage

@@ design/pit4ch_if.sv @@
interface pit4ch_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [8:0]  address;
   logic [31:0] write_data;

   modport source (output valid, output func, output address, output write_data,
                   input ready);
   modport sink (input valid, input func, input address, input write_data,
                 output ready);
endinterface

interface pit4ch_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] read_data;
   logic        irq;
   logic        access_error;

   modport source (output valid, output read_data, output irq, output access_error,
                   input ready);
   modport sink (input valid, input read_data, input irq, input access_error,
                 output ready);
endinterface

@@ design/periodic_interrupt_timer_4ch.sv @@
// Periodic interrupt timer with NUM_CHANNELS down-counters behind a register bus.
// Each request word is a tick, a register read or a register write, and gives one
// response word carrying read data, the interrupt level after the request and an
// access error flag. One request is taken every clock cycle unless the response side
// stalls; an accepted request is held in the input register, then decode and the
// single-pass update of all channel registers write the response register.
// Back-pressure on the response side holds both stages.
module periodic_interrupt_timer_4ch #(
   parameter int NUM_CHANNELS = pit4ch_pkg::NUM_CHANNELS_DEF,
   parameter int COUNT_WIDTH  = pit4ch_pkg::COUNT_WIDTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   pit4ch_req_if.sink   req_chan,
   pit4ch_rsp_if.source rsp_chan
);
   import pit4ch_pkg::*;

   logic              in_valid_ff;
   logic [FUNC_W-1:0] func_ff;
   logic [ADDR_W-1:0] address_ff;
   logic [DATA_W-1:0] write_data_ff;

   logic              out_valid_ff;
   logic [DATA_W-1:0] read_data_ff, read_data_in;
   logic              irq_ff, irq_in;
   logic              err_ff;

   logic [CTRL_W-1:0] mod_ctrl_ff, mod_ctrl_in;
   logic              dis_next;
   logic              advance;
   logic              fire;
   access_type        acc;

   logic [DATA_W-1:0] ch_rdata [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] ch_irq;

   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign fire           = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;

   pit4ch_decode #(.NUM_CHANNELS(NUM_CHANNELS)) u_decode (
      .fire    (fire),
      .func    (func_ff),
      .address (address_ff),
      .acc     (acc)
   );

   always_comb begin
      mod_ctrl_in = mod_ctrl_ff;
      if (acc.write && acc.mod_hit) mod_ctrl_in = write_data_ff[CTRL_W-1:0];
      dis_next = mod_ctrl_in[MOD_DISABLE_BIT];
   end

   for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_ch
      pit4ch_channel #(.COUNT_WIDTH(COUNT_WIDTH), .CH_ID(c)) u_channel (
         .clock      (clock),
         .reset      (reset),
         .acc        (acc),
         .write_data (write_data_ff),
         .dis_next   (dis_next),
         .read_data  (ch_rdata[c]),
         .irq_req    (ch_irq[c])
      );
   end

   always_comb begin
      read_data_in = '0;
      if (acc.read && acc.mod_hit) read_data_in = DATA_W'(mod_ctrl_ff);
      for (int c = 0; c < NUM_CHANNELS; c++) read_data_in = read_data_in | ch_rdata[c];
      irq_in = !dis_next && (|ch_irq);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mod_ctrl_ff  <= '0;
      end else begin
         if (req_chan.ready) in_valid_ff <= req_chan.valid;
         if (advance) out_valid_ff <= in_valid_ff;
         mod_ctrl_ff <= mod_ctrl_in;
      end
   end

   // payload stages: capture whenever the stage is ready (input) or fires (output), hold otherwise
   always_ff @(posedge clock) begin
      if (req_chan.ready) begin
         func_ff       <= req_chan.func;
         address_ff    <= req_chan.address;
         write_data_ff <= req_chan.write_data;
      end
      if (fire) begin
         read_data_ff <= read_data_in;
         irq_ff       <= irq_in;
         err_ff       <= acc.err;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.read_data    = read_data_ff;
   assign rsp_chan.irq          = irq_ff;
   assign rsp_chan.access_error = err_ff;

endmodule

@@ design/pit4ch_decode.sv @@
module pit4ch_decode #(
   parameter int NUM_CHANNELS = pit4ch_pkg::NUM_CHANNELS_DEF
) (
   input  logic                        fire,
   input  logic [pit4ch_pkg::FUNC_W-1:0] func,
   input  logic [pit4ch_pkg::ADDR_W-1:0] address,
   output pit4ch_pkg::access_type      acc
);
   import pit4ch_pkg::*;

   localparam logic [ADDR_W-1:0] CH_LO = ADDR_W'(CH_BASE);
   localparam logic [ADDR_W-1:0] CH_HI = ADDR_W'(CH_BASE + CH_STRIDE * NUM_CHANNELS);

   logic               is_read;
   logic               is_write;
   logic               mod_hit;
   logic               ch_hit;
   logic [ADDR_W-1:0]  ch_ofs;

   always_comb begin
      is_read  = (func == FUNC_READ);
      is_write = (func == FUNC_WRITE);
      mod_hit  = (address == ADDR_W'(MOD_CTRL_ADDR));
      ch_ofs   = address - CH_LO;
      ch_hit   = (address >= CH_LO) && (address < CH_HI) && (address[1:0] == 2'b00);

      acc.tick    = fire && (func == FUNC_TICK);
      acc.read    = fire && is_read;
      acc.write   = fire && is_write;
      acc.mod_hit = mod_hit;
      acc.ch_hit  = ch_hit;
      acc.ch_num  = ch_ofs[4 +: CHNUM_W];
      acc.reg_sel = reg_sel_type'(ch_ofs[3:2]);
      // unknown offset on any access, or a write to the current value
      acc.err     = (is_read || is_write) && !mod_hit &&
                    (!ch_hit || (is_write && reg_sel_type'(ch_ofs[3:2]) == REG_CVAL));
   end

endmodule

@@ design/pit4ch_channel.sv @@
module pit4ch_channel #(
   parameter int COUNT_WIDTH = pit4ch_pkg::COUNT_WIDTH_DEF,
   parameter int CH_ID       = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pit4ch_pkg::access_type        acc,
   input  logic [pit4ch_pkg::DATA_W-1:0] write_data,
   input  logic                          dis_next,
   output logic [pit4ch_pkg::DATA_W-1:0] read_data,
   output logic                          irq_req
);
   import pit4ch_pkg::*;

   logic [COUNT_WIDTH-1:0] load_ff, load_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [CTRL_W-1:0]      ctrl_ff, ctrl_in;
   logic                   flag_ff, flag_in;
   logic                   running_ff, running_in;
   logic                   sel;
   logic                   apply;
   logic                   want;

   always_comb begin
      sel = acc.ch_hit && (acc.ch_num == CHNUM_W'(CH_ID));

      load_in    = load_ff;
      ctrl_in    = ctrl_ff;
      flag_in    = flag_ff;
      count_in   = count_ff;
      running_in = running_ff;

      if (sel && acc.write) begin
         case (acc.reg_sel)
            REG_LOAD: load_in = write_data[COUNT_WIDTH-1:0];
            REG_CTRL: ctrl_in = write_data[CTRL_W-1:0];
            REG_FLAG: begin
               if (write_data[FLAG_CLR_BIT]) flag_in = 1'b0;
            end
            default: ;
         endcase
      end

      apply = (acc.write && acc.mod_hit) ||
              (sel && acc.write && (acc.reg_sel == REG_LOAD || acc.reg_sel == REG_CTRL));
      want  = ctrl_in[CTL_EN_BIT] && !dis_next;

      if (apply) begin
         // load the counter when the channel starts running
         if (want && !running_ff) count_in = load_ff;
         running_in = want;
      end else if (acc.tick && running_ff) begin
         if (count_ff == '0) begin
            count_in = load_ff;
         end else begin
            count_in = count_ff - 1'b1;
            if (count_ff == COUNT_WIDTH'(1)) flag_in = 1'b1;
         end
      end

      read_data = '0;
      if (sel && acc.read) begin
         case (acc.reg_sel)
            REG_LOAD: read_data = DATA_W'(load_ff);
            REG_CVAL: read_data = DATA_W'(count_ff);
            REG_CTRL: read_data = DATA_W'(ctrl_ff);
            REG_FLAG: read_data = DATA_W'(flag_ff);
            default:  read_data = '0;
         endcase
      end

      irq_req = ctrl_in[CTL_EN_BIT] && ctrl_in[CTL_IE_BIT] && flag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff    <= '0;
         count_ff   <= '0;
         ctrl_ff    <= '0;
         flag_ff    <= 1'b0;
         running_ff <= 1'b0;
      end else begin
         load_ff    <= load_in;
         count_ff   <= count_in;
         ctrl_ff    <= ctrl_in;
         flag_ff    <= flag_in;
         running_ff <= running_in;
      end
   end

endmodule

@@ design/pit4ch_checker.sv @@
module pit4ch_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_read_data,
   input logic        rsp_access_error
);

   // response register empties on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response word stays
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // a failed access never returns data
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_access_error |-> rsp_read_data == '0)
      else $error("read data on access error");

endmodule

bind periodic_interrupt_timer_4ch pit4ch_checker u_pit4ch_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_read_data    (rsp_chan.read_data),
   .rsp_access_error (rsp_chan.access_error)
);
